FILE: rtl/tlf_pkg.sv
`default_nettype none

package tlf_pkg;

  localparam int BUF_W  = 32;                 // line store depth
  localparam int COL_W  = $clog2(BUF_W + 1);  // column, 0..BUF_W
  localparam int IDX_W  = $clog2(BUF_W);      // store index
  localparam int CHAR_W = 8;
  localparam int CFG_W  = 6;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int REG_BIT = 2;                 // paddr bit that selects the register

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'd32;

  localparam logic [CFG_W-1:0] FOLD_MIN   = 6'd2;
  localparam logic [CFG_W-1:0] STEP_MIN   = 6'd1;
  localparam logic [CFG_W-1:0] FOLD_RESET = 6'd10;
  localparam logic [CFG_W-1:0] STEP_RESET = 6'd8;

  // register index codes
  localparam logic REG_FOLD = 1'b0;
  localparam logic REG_TAB  = 1'b1;

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_TAB   = 2'd1,
    KIND_NL    = 2'd2
  } kind_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    kind_t             kind;
    logic [COL_W-1:0]  fold;   // effective fold column, 2..BUF_W
    logic [CFG_W-1:0]  step;   // effective tab step, 1..63
  } item_t;

endpackage

`default_nettype wire

FILE: rtl/tlf_if.sv
`default_nettype none

interface tlf_in_if;
  logic                      valid;
  logic                      ready;
  logic [tlf_pkg::CHAR_W-1:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink (input valid, input in_char, output ready);
endinterface

interface tlf_out_if;
  logic                      valid;
  logic                      ready;
  logic [tlf_pkg::CHAR_W-1:0] out_char;
  logic                      last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink (input valid, input out_char, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/tlf_front.sv
`default_nettype none

// Classifies each character and tags it with the settings in force.
module tlf_front (
  tlf_in_if.sink                       chars,
  input  logic [tlf_pkg::CFG_W-1:0]    fold_column,
  input  logic [tlf_pkg::CFG_W-1:0]    tab_step,
  output tlf_pkg::item_t               item,
  output logic                         item_valid,
  input  logic                         item_ready
);

  logic [tlf_pkg::COL_W-1:0] fold_eff;
  logic [tlf_pkg::CFG_W-1:0] step_eff;
  tlf_pkg::kind_t            kind;

  always_comb begin
    if (fold_column < tlf_pkg::FOLD_MIN) begin
      fold_eff = tlf_pkg::COL_W'(tlf_pkg::FOLD_MIN);
    end else if (fold_column > tlf_pkg::CFG_W'(tlf_pkg::BUF_W)) begin
      fold_eff = tlf_pkg::COL_W'(tlf_pkg::BUF_W);
    end else begin
      fold_eff = tlf_pkg::COL_W'(fold_column);
    end
    step_eff = (tab_step == '0) ? tlf_pkg::STEP_MIN : tab_step;
    if (chars.in_char == tlf_pkg::CH_TAB) begin
      kind = tlf_pkg::KIND_TAB;
    end else if (chars.in_char == tlf_pkg::CH_NL) begin
      kind = tlf_pkg::KIND_NL;
    end else begin
      kind = tlf_pkg::KIND_PLAIN;
    end
  end

  assign item.ch     = chars.in_char;
  assign item.kind   = kind;
  assign item.fold   = fold_eff;
  assign item.step   = step_eff;
  assign item_valid  = chars.valid;
  assign chars.ready = item_ready;

endmodule

`default_nettype wire

FILE: rtl/tlf_queue.sv
`default_nettype none

// Two-entry queue between classifier and line engine.
module tlf_queue (
  input  logic           clk,
  input  logic           rst,
  input  tlf_pkg::item_t push_item,
  input  logic           push_valid,
  output logic           push_ready,
  output tlf_pkg::item_t pop_item,
  output logic           pop_valid,
  input  logic           pop_ready
);

  tlf_pkg::item_t              slots [tlf_pkg::QUEUE_DEPTH];
  logic [tlf_pkg::QPTR_W-1:0]  wr_ptr;
  logic [tlf_pkg::QPTR_W-1:0]  rd_ptr;
  logic [tlf_pkg::QCNT_W-1:0]  count;
  logic                        do_push;
  logic                        do_pop;

  assign push_ready = (count != tlf_pkg::QCNT_W'(tlf_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tlf_back.sv
`default_nettype none

// Line engine: owns the line store, column and last-blank tracker.
// Tabs run a restoring remainder unit, then fill blanks one per cycle.
// Emission streams the store through a registered read port; entries past
// the cut are written back to the front of the store on the same stream.
module tlf_back (
  input  logic           clk,
  input  logic           rst,
  input  tlf_pkg::item_t item,
  input  logic           item_valid,
  output logic           item_ready,
  tlf_out_if.source      lines
);

  localparam int CW = tlf_pkg::COL_W;
  localparam int IW = tlf_pkg::IDX_W;
  localparam int SW = tlf_pkg::CFG_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_FILL = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state;

  logic [tlf_pkg::CHAR_W-1:0] store [tlf_pkg::BUF_W];

  logic [CW-1:0] column;
  logic [IW-1:0] lastb;      // last blank at index >= 1, zero if none

  // tab work
  logic [IW-1:0] t_pos;
  logic [CW-1:0] t_fold;
  logic [SW-1:0] t_step;
  logic [SW-1:0] rem;
  logic [IW-1:0] dq;
  logic [2:0]    dcnt;
  logic [IW-1:0] fill_pos;

  // emission stream
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] e_len;
  logic [CW-1:0] e_cut;
  logic          rv;
  logic          r_out;
  logic [IW-1:0] r_waddr;
  logic [tlf_pkg::CHAR_W-1:0] rdata;

  // output register
  logic                       ov;
  logic [tlf_pkg::CHAR_W-1:0] o_char;
  logic                       o_last;

  // store write port
  logic                       we;
  logic [IW-1:0]              waddr;
  logic [tlf_pkg::CHAR_W-1:0] wdata;

  logic [IW-1:0] pos;
  logic [CW-1:0] p1;
  logic [IW-1:0] lb_new;
  logic [CW-1:0] cut;
  logic [SW:0]   tdiv;
  logic [SW:0]   nstop;
  logic [CW-1:0] tp1;
  logic [CW-1:0] hi;
  logic [CW-1:0] tab_end;
  logic          take;
  logic          out_free;
  logic          move;
  logic          cpy;
  logic          issue;
  logic          nl_push;
  logic          fill_done;

  assign item_ready = (state == ST_IDLE);
  assign take       = item_valid && item_ready;

  always_comb begin
    pos = (column >= CW'(tlf_pkg::BUF_W)) ? IW'(tlf_pkg::BUF_W - 1) : column[IW-1:0];
    p1  = {1'b0, pos} + 1'b1;
    lb_new = ((item.ch == tlf_pkg::CH_BLANK) && (pos != '0)) ? pos : lastb;
    cut = (lb_new == '0) ? p1 : ({1'b0, lb_new} + 1'b1);

    tdiv  = {rem, dq[IW-1]};
    nstop = (SW+1)'(t_pos) + {1'b0, t_step} - {1'b0, rem};
    tp1   = {1'b0, t_pos} + 1'b1;
    hi    = (t_fold > tp1) ? t_fold : tp1;
    tab_end = (nstop > (SW+1)'(hi)) ? hi : nstop[CW-1:0];
    fill_done = (({1'b0, fill_pos} + 1'b1) == tab_end);

    out_free = !ov || lines.ready;
    move     = rv && r_out && out_free;
    cpy      = rv && !r_out;
    issue    = (state == ST_EMIT) && (rd_idx < e_len) && (!rv || move || cpy);
    nl_push  = (state == ST_EMIT) && (rd_idx == e_len) && !rv && out_free;
  end

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = item.ch;
    case (state)
      ST_IDLE: begin
        we = take && (item.kind == tlf_pkg::KIND_PLAIN);
      end
      ST_FILL: begin
        we    = 1'b1;
        waddr = fill_pos;
        wdata = tlf_pkg::CH_BLANK;
      end
      ST_EMIT: begin
        we    = cpy;
        waddr = r_waddr;
        wdata = rdata;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    if (issue) begin
      rdata <= store[rd_idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      r_out   <= (rd_idx < e_cut);
      r_waddr <= IW'(rd_idx - e_cut);
    end
    if (move) begin
      o_char <= rdata;
      o_last <= 1'b0;
    end else if (nl_push) begin
      o_char <= tlf_pkg::CH_NL;
      o_last <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      column <= '0;
      lastb  <= '0;
      rv     <= 1'b0;
      ov     <= 1'b0;
    end else begin
      if (issue) begin
        rv <= 1'b1;
      end else if (move || cpy) begin
        rv <= 1'b0;
      end
      if (move || nl_push) begin
        ov <= 1'b1;
      end else if (lines.ready) begin
        ov <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (take) begin
            case (item.kind)
              tlf_pkg::KIND_PLAIN: begin
                if (p1 < item.fold) begin
                  column <= p1;
                  lastb  <= lb_new;
                end else begin
                  column <= p1 - cut;
                  lastb  <= '0;
                  e_len  <= p1;
                  e_cut  <= cut;
                  rd_idx <= '0;
                  state  <= ST_EMIT;
                end
              end
              tlf_pkg::KIND_NL: begin
                column <= '0;
                lastb  <= '0;
                if (pos != '0) begin
                  e_len  <= CW'(pos);
                  e_cut  <= CW'(pos);
                  rd_idx <= '0;
                  state  <= ST_EMIT;
                end
              end
              tlf_pkg::KIND_TAB: begin
                t_pos  <= pos;
                t_fold <= item.fold;
                t_step <= item.step;
                rem    <= '0;
                dq     <= pos;
                dcnt   <= '0;
                state  <= ST_DIV;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (tdiv >= {1'b0, t_step}) begin
            rem <= SW'(tdiv - {1'b0, t_step});
          end else begin
            rem <= tdiv[SW-1:0];
          end
          dq   <= {dq[IW-2:0], 1'b0};
          dcnt <= dcnt + 1'b1;
          if (dcnt == 3'(IW - 1)) begin
            fill_pos <= t_pos;
            state    <= ST_FILL;
          end
        end
        ST_FILL: begin
          if (fill_done) begin
            if (tab_end < t_fold) begin
              column <= tab_end;
              if (tab_end > CW'(1)) begin
                lastb <= IW'(tab_end - 1'b1);
              end
              state <= ST_IDLE;
            end else begin
              column <= '0;
              lastb  <= '0;
              e_len  <= tab_end;
              e_cut  <= tab_end;
              rd_idx <= '0;
              state  <= ST_EMIT;
            end
          end else begin
            fill_pos <= fill_pos + 1'b1;
          end
        end
        ST_EMIT: begin
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (nl_push) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign lines.valid    = ov;
  assign lines.out_char = o_char;
  assign lines.last     = o_last;

endmodule

`default_nettype wire

FILE: rtl/text_line_folder_unit.sv
`default_nettype none

// Channel    Beat carries               Direction
// chars      in_char (8b)               into the block
// lines      out_char (8b), last (1b)   out of the block
// apb        fold_column, tab_step      register writes and reads
//
// A plain character that does not fold is taken straight by the line engine;
// with the two-entry queue, characters enter one per cycle while the engine
// is idle. A fold, or a newline after a nonempty line, then holds the engine:
// one store read per buffered column through the registered read port
// (characters out, the tail of a fold copied to the front), then the closing
// newline beat. A tab runs the remainder unit, then writes its blanks. Reset
// clears the column, the queue and the output register; the line store is not
// cleared. A stalled lines channel holds its beat and the engine; chars keeps
// filling the queue until it is full.
module text_line_folder_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlf_pkg::ADDR_W-1:0]    paddr,
  input  logic [tlf_pkg::DATA_W-1:0]    pwdata,
  output logic [tlf_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  tlf_in_if.sink                        chars,
  tlf_out_if.source                     lines
);

  // raw register values; front end clamps them per character
  logic [tlf_pkg::CFG_W-1:0] fold_column;
  logic [tlf_pkg::CFG_W-1:0] tab_step;
  logic                      wr_en;

  tlf_pkg::item_t f_item;
  logic           f_valid;
  logic           f_ready;
  tlf_pkg::item_t q_item;
  logic           q_valid;
  logic           q_ready;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // only the register-select bit is decoded
  always_ff @(posedge clk) begin
    if (rst) begin
      fold_column <= tlf_pkg::FOLD_RESET;
      tab_step    <= tlf_pkg::STEP_RESET;
    end else if (wr_en) begin
      if (paddr[tlf_pkg::REG_BIT] == tlf_pkg::REG_TAB) begin
        tab_step <= pwdata[tlf_pkg::CFG_W-1:0];
      end else begin
        fold_column <= pwdata[tlf_pkg::CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[tlf_pkg::REG_BIT] == tlf_pkg::REG_TAB) begin
      prdata = tlf_pkg::DATA_W'(tab_step);
    end else begin
      prdata = tlf_pkg::DATA_W'(fold_column);
    end
  end

  tlf_front u_front (
    .chars       (chars),
    .fold_column (fold_column),
    .tab_step    (tab_step),
    .item        (f_item),
    .item_valid  (f_valid),
    .item_ready  (f_ready)
  );

  tlf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (f_item),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_item   (q_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  tlf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (q_item),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .lines      (lines)
  );

endmodule

`default_nettype wire

FILE: rtl/tlf_checker.sv
`default_nettype none

module tlf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic                          pready,
  input logic [tlf_pkg::ADDR_W-1:0]    paddr,
  input logic [tlf_pkg::DATA_W-1:0]    pwdata,
  input logic [tlf_pkg::DATA_W-1:0]    prdata,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tlf_pkg::CHAR_W-1:0]    out_char,
  input logic                          out_last
);

  // a line always closes with a newline
  a_last_is_nl: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_char == tlf_pkg::CH_NL)
    else $error("last beat is not a newline");

  // line body never carries a tab or newline
  a_body_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> out_char != tlf_pkg::CH_NL && out_char != tlf_pkg::CH_TAB)
    else $error("control character inside a line");

  a_fold_readback: assert property (@(posedge clk) disable iff (rst)
    (!rst && psel && penable && pwrite && pready &&
     paddr[tlf_pkg::REG_BIT] == tlf_pkg::REG_FOLD) ##1
    (psel && !pwrite && paddr[tlf_pkg::REG_BIT] == tlf_pkg::REG_FOLD)
    |-> prdata == tlf_pkg::DATA_W'($past(pwdata[tlf_pkg::CFG_W-1:0])))
    else $error("fold column readback mismatch");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("stalled beat changed");

endmodule

bind text_line_folder_unit tlf_checker u_tlf_checker (
  .clk       (clk),
  .rst       (rst),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .pready    (pready),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .out_valid (lines.valid),
  .out_ready (lines.ready),
  .out_char  (lines.out_char),
  .out_last  (lines.last)
);

`default_nettype wire
